// ===== rtl/binary_trie_max_xor_defines.svh =====
// Assertion macros for the binary trie block.
// BTMX_ASSERT is disabled during reset; BTMX_ASSERT_RST also checks the reset cycles.
`ifndef BINARY_TRIE_MAX_XOR_DEFINES_SVH
`define BINARY_TRIE_MAX_XOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define BTMX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define BTMX_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define BTMX_ASSERT(lbl, prop, msg)
`define BTMX_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== rtl/btmx_pkg.sv =====
package btmx_pkg;

    localparam int KEY_BITS_DEF   = 32;
    localparam int POOL_NODES_DEF = 4096;
    localparam int KEY_W          = 32;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key_value;
    } req_t;

    typedef struct packed {
        logic [KEY_W-1:0] xor_max;
        logic [1:0]       status;
    } rsp_t;

endpackage

// ===== rtl/binary_trie_max_xor.sv =====
// Binary trie of KEY_BITS-bit keys with maximum-XOR query. Each request either
// inserts key_value or asks for the largest key_value XOR stored-key; one
// response comes back per request. Nodes live in a POOL_NODES-entry node table
// (one RAM, a pair of child indices per entry, registered read); the root
// lives in flip-flops, so no clearing pass is needed after reset. A request
// walks one trie level per clock, the node-table read for the next level
// being issued in the same cycle the current level is decided, so that read
// port paces the walk. A query or an insert of a stored key goes from the
// walk straight to S_DONE; an insert that allocates new nodes passes through
// S_ALLOC where needed and then S_LEAF, which nulls the new leaf; and an
// empty-trie query or an insert rejected because fewer than KEY_BITS nodes
// are free goes straight from idle to S_DONE. s_ready is high only while
// the walker is idle; a finished response waits in an output register, so a
// new request is taken even while m_ready is low. Status: 0 ok, 1 query on an
// empty trie (xor_max 0), 2 insert rejected because the pool is full (trie
// unchanged). xor_max is 0 for inserts and errors.
`include "binary_trie_max_xor_defines.svh"

module binary_trie_max_xor #(
    parameter int KEY_BITS   = btmx_pkg::KEY_BITS_DEF,
    parameter int POOL_NODES = btmx_pkg::POOL_NODES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  btmx_pkg::req_t  s_req,
    output logic            m_valid,
    input  logic            m_ready,
    output btmx_pkg::rsp_t  m_rsp
);

    localparam int NODE_W  = $clog2(POOL_NODES);
    localparam int ENTRY_W = 2 * NODE_W;
    localparam int NFN_W   = NODE_W + 1;
    localparam int LVL_W   = $clog2(KEY_BITS);

    // Highest next-free value at which KEY_BITS nodes are still available.
    localparam logic [NFN_W-1:0] FULL_LIMIT = NFN_W'(POOL_NODES - KEY_BITS);
    localparam logic [NFN_W-1:0] NFN_MAX    = NFN_W'(POOL_NODES);
    localparam logic [LVL_W-1:0] LVL_TOP    = LVL_W'(KEY_BITS - 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;  // follow existing nodes, one level per cycle
    localparam logic [2:0] S_ALLOC = 3'd2;  // chain freshly allocated nodes
    localparam logic [2:0] S_LEAF  = 3'd3;  // null the last allocated node
    localparam logic [2:0] S_DONE  = 3'd4;  // hand response to output register

    logic [2:0]          state_reg, state_next;
    logic [LVL_W-1:0]    lvl_reg, lvl_next;
    logic [NODE_W-1:0]   node_reg, node_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic                op_reg, op_next;
    logic [KEY_BITS-1:0] acc_reg, acc_next;
    logic [NFN_W-1:0]    nfn_reg, nfn_next;
    logic [ENTRY_W-1:0]  root_reg, root_next;
    btmx_pkg::rsp_t      res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    btmx_pkg::rsp_t      m_rsp_reg, m_rsp_next;

    // Node table port.
    logic                ram_we;
    logic [NODE_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [NODE_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    // Per-level decode.
    logic [ENTRY_W-1:0]  cur_entry;
    logic                key_bit;
    logic [NODE_W-1:0]   child_same;
    logic [NODE_W-1:0]   child_opp;
    logic                take_opp;
    logic [NODE_W-1:0]   walk_next;
    logic [NODE_W-1:0]   nfn_idx;
    logic [ENTRY_W-1:0]  upd_entry;
    logic [ENTRY_W-1:0]  link_entry;
    logic                pool_full;
    logic                s_fire;
    logic                out_free;

    btmx_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (POOL_NODES)
    ) u_node_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_rsp    = m_rsp_reg;
    assign out_free = !m_valid_reg || m_ready;

    // The root is the only node 0 and sits in flip-flops; every other node
    // was read from the table in the previous cycle.
    assign cur_entry  = (node_reg == '0) ? root_reg : ram_rdata;
    assign key_bit    = key_reg[lvl_reg];
    assign child_same = key_bit ? cur_entry[ENTRY_W-1:NODE_W] : cur_entry[NODE_W-1:0];
    assign child_opp  = key_bit ? cur_entry[NODE_W-1:0] : cur_entry[ENTRY_W-1:NODE_W];
    assign take_opp   = (op_reg == btmx_pkg::REQ_QUERY) && (child_opp != '0);
    assign walk_next  = take_opp ? child_opp : child_same;
    assign nfn_idx    = nfn_reg[NODE_W-1:0];
    assign pool_full  = (nfn_reg > FULL_LIMIT);

    // Existing parent gains the new child; a fresh parent has only that child.
    assign upd_entry  = key_bit ? {nfn_idx, cur_entry[NODE_W-1:0]}
                                : {cur_entry[ENTRY_W-1:NODE_W], nfn_idx};
    assign link_entry = key_bit ? {nfn_idx, {NODE_W{1'b0}}}
                                : {{NODE_W{1'b0}}, nfn_idx};

    // Issue the read for the next level while deciding this one.
    assign ram_raddr = walk_next;

    always_comb begin
        state_next   = state_reg;
        lvl_next     = lvl_reg;
        node_next    = node_reg;
        key_next     = key_reg;
        op_next      = op_reg;
        acc_next     = acc_reg;
        nfn_next     = nfn_reg;
        root_next    = root_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_rsp_next   = m_rsp_reg;
        ram_we       = 1'b0;
        ram_waddr    = node_reg;
        ram_wdata    = link_entry;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    key_next  = KEY_BITS'(s_req.key_value);
                    op_next   = s_req.req_type;
                    acc_next  = '0;
                    node_next = '0;
                    lvl_next  = LVL_TOP;
                    res_next  = '{xor_max: '0, status: btmx_pkg::ST_OK};
                    if (s_req.req_type == btmx_pkg::REQ_QUERY && root_reg == '0) begin
                        res_next.status = btmx_pkg::ST_EMPTY;
                        state_next      = S_DONE;
                    end else if (s_req.req_type == btmx_pkg::REQ_INSERT && pool_full) begin
                        res_next.status = btmx_pkg::ST_FULL;
                        state_next      = S_DONE;
                    end else begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (walk_next != '0) begin
                    if (take_opp) begin
                        acc_next = acc_reg | (KEY_BITS'(1) << lvl_reg);
                    end
                    if (lvl_reg == '0) begin
                        if (op_reg == btmx_pkg::REQ_QUERY) begin
                            res_next.xor_max = btmx_pkg::KEY_W'(acc_next);
                        end
                        state_next = S_DONE;
                    end else begin
                        lvl_next  = lvl_reg - 1'b1;
                        node_next = walk_next;
                    end
                end else if (op_reg == btmx_pkg::REQ_QUERY) begin
                    // Broken path: return the bits gathered so far.
                    res_next.xor_max = btmx_pkg::KEY_W'(acc_reg);
                    state_next       = S_DONE;
                end else begin
                    // Missing child: link a new node under the current one.
                    if (node_reg == '0) begin
                        root_next = upd_entry;
                    end else begin
                        ram_we    = 1'b1;
                        ram_wdata = upd_entry;
                    end
                    node_next = nfn_idx;
                    nfn_next  = nfn_reg + 1'b1;
                    if (lvl_reg == '0) begin
                        state_next = S_LEAF;
                    end else begin
                        lvl_next   = lvl_reg - 1'b1;
                        state_next = S_ALLOC;
                    end
                end
            end
            S_ALLOC: begin
                ram_we    = 1'b1;
                ram_wdata = link_entry;
                node_next = nfn_idx;
                nfn_next  = nfn_reg + 1'b1;
                if (lvl_reg == '0) begin
                    state_next = S_LEAF;
                end else begin
                    lvl_next = lvl_reg - 1'b1;
                end
            end
            S_LEAF: begin
                ram_we     = 1'b1;
                ram_wdata  = '0;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_rsp_next   = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            nfn_reg     <= NFN_W'(1);
            root_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            nfn_reg     <= nfn_next;
            root_reg    <= root_next;
            m_valid_reg <= m_valid_next;
        end
        lvl_reg   <= lvl_next;
        node_reg  <= node_next;
        key_reg   <= key_next;
        op_reg    <= op_next;
        acc_reg   <= acc_next;
        res_reg   <= res_next;
        m_rsp_reg <= m_rsp_next;
    end

    // Allocation never runs past the end of the pool.
    `BTMX_ASSERT(a_nfn_bound, nfn_reg <= NFN_MAX, "next free node beyond pool")
    // The root lives in flip-flops; the table must never be written at node 0.
    `BTMX_ASSERT(a_no_root_write, ram_we |-> ram_waddr != '0, "node table write at root")
    // A rejected insert must leave the allocator untouched.
    `BTMX_ASSERT(a_full_no_alloc, s_fire && s_req.req_type == btmx_pkg::REQ_INSERT && pool_full |=> $stable(nfn_reg), "allocation after pool full")
    // Reset empties the trie and drops any pending response.
    `BTMX_ASSERT_RST(a_reset_state, !aresetn |=> root_reg == '0 && nfn_reg == NFN_W'(1) && !m_valid_reg, "bad state after reset")

endmodule

// ===== rtl/btmx_ram.sv =====
module btmx_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
